@@ hdl/imu_pkt_pkg.sv @@
// ----------------------------------------------------------------------------
// imu_pkt_pkg
// Shared types and constants for the inertial sensor packet decoder.
// ----------------------------------------------------------------------------
package imu_pkt_pkg;

  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 16;
  localparam int AXIS_W  = 28;
  localparam int FS_W    = 12;
  localparam int POS_W   = 4;
  localparam int NUM_AXIS_BYTES = 6;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;

  // slot positions
  localparam logic [POS_W-1:0] POS_HEADER    = 4'd0;
  localparam logic [POS_W-1:0] POS_KIND      = 4'd1;
  localparam logic [POS_W-1:0] POS_AXIS_LAST = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST      = 4'd10;

  // kind byte codes on the wire
  localparam logic [BYTE_W-1:0] CODE_ACCEL = 8'h51;
  localparam logic [BYTE_W-1:0] CODE_RATE  = 8'h52;
  localparam logic [BYTE_W-1:0] CODE_ANGLE = 8'h53;

  // full scale of each kind, raw full range is 32768
  localparam logic [FS_W-1:0] FS_ACCEL = 12'd16;
  localparam logic [FS_W-1:0] FS_RATE  = 12'd2000;
  localparam logic [FS_W-1:0] FS_ANGLE = 12'd180;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  // what the slot tracker reports for the byte at its input
  typedef struct packed {
    logic                    hit;
    kind_t                   kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } slot_evt_t;

endpackage

@@ hdl/imu_pkt_slot.sv @@
// ----------------------------------------------------------------------------
// imu_pkt_slot
// Slot position counter, header check, kind capture and axis byte storage.
// ----------------------------------------------------------------------------
module imu_pkt_slot (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [imu_pkt_pkg::BYTE_W-1:0] cfg_data,
  input  logic                           in_fire,
  input  logic [imu_pkt_pkg::BYTE_W-1:0] rx_byte,
  input  logic                           first_of_frame,
  output logic                           at_last,
  output imu_pkt_pkg::slot_evt_t         evt
);
  import imu_pkt_pkg::*;

  logic [BYTE_W-1:0] header_r;
  logic [POS_W-1:0]  slot_pos_r;
  logic [POS_W-1:0]  slot_pos_nxt;
  logic              hdr_ok_r;
  logic [BYTE_W-1:0] kind_code_r;
  logic [BYTE_W-1:0] axis_bytes_r [NUM_AXIS_BYTES];
  logic [POS_W-1:0]  pos;
  logic              known;
  kind_t             kind;

  always_comb begin
    pos = first_of_frame ? POS_HEADER : slot_pos_r;
    if (pos > POS_LAST) begin
      pos = POS_HEADER;
    end
    slot_pos_nxt = (pos == POS_LAST) ? POS_HEADER : pos + 4'd1;
  end

  always_comb begin
    unique case (kind_code_r)
      CODE_ACCEL: begin
        known = 1'b1;
        kind  = KIND_ACCEL;
      end
      CODE_RATE: begin
        known = 1'b1;
        kind  = KIND_RATE;
      end
      CODE_ANGLE: begin
        known = 1'b1;
        kind  = KIND_ANGLE;
      end
      default: begin
        known = 1'b0;
        kind  = KIND_ACCEL;
      end
    endcase
  end

  assign at_last = (slot_pos_r == POS_LAST);

  always_comb begin
    evt.hit   = (pos == POS_LAST) && hdr_ok_r && known;
    evt.kind  = kind;
    evt.raw_x = {axis_bytes_r[1], axis_bytes_r[0]};
    evt.raw_y = {axis_bytes_r[3], axis_bytes_r[2]};
    evt.raw_z = {axis_bytes_r[5], axis_bytes_r[4]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= HEADER_RESET;
      slot_pos_r  <= POS_HEADER;
      hdr_ok_r    <= 1'b0;
      kind_code_r <= '0;
    end else begin
      if (cfg_valid) begin
        header_r <= cfg_data;
      end
      if (in_fire) begin
        slot_pos_r <= slot_pos_nxt;
        if (pos == POS_HEADER) begin
          hdr_ok_r <= (rx_byte == header_r);
        end
        if (pos == POS_KIND) begin
          kind_code_r <= rx_byte;
        end
      end
    end
  end

  // axis bytes carry no reset, they are always written before use
  always_ff @(posedge clk) begin
    if (in_fire && pos > POS_KIND && pos <= POS_AXIS_LAST) begin
      axis_bytes_r[3'(pos - 4'd2)] <= rx_byte;
    end
  end

endmodule

@@ hdl/imu_pkt_scale.sv @@
// ----------------------------------------------------------------------------
// imu_pkt_scale
// Scales one raw axis to signed fixed point by the kind's full scale.
// ----------------------------------------------------------------------------
module imu_pkt_scale #(
  parameter int OUT_FRAC_BITS = imu_pkt_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic signed [imu_pkt_pkg::RAW_W-1:0]  raw,
  input  imu_pkt_pkg::kind_t                    kind,
  output logic signed [imu_pkt_pkg::AXIS_W-1:0] value
);
  import imu_pkt_pkg::*;

  localparam int PROD_W = RAW_W + FS_W;
  localparam int WW     = PROD_W + OUT_FRAC_BITS + 2;
  localparam int SHIFT  = 15;

  localparam logic signed [WW-1:0] SAT_HI = {{(WW-AXIS_W+1){1'b0}}, {(AXIS_W-1){1'b1}}};
  localparam logic signed [WW-1:0] SAT_LO = {{(WW-AXIS_W+1){1'b1}}, {(AXIS_W-1){1'b0}}};
  localparam logic signed [WW-1:0] HALF   = {{(WW-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};

  logic [FS_W-1:0]          fs;
  logic signed [PROD_W-1:0] prod;
  logic signed [WW-1:0]     wide;
  logic signed [WW-1:0]     shifted;

  always_comb begin
    case (kind)
      KIND_ACCEL: fs = FS_ACCEL;
      KIND_RATE:  fs = FS_RATE;
      KIND_ANGLE: fs = FS_ANGLE;
      default:    fs = '0;
    endcase
  end

  // value = round(raw * fs * 2^frac / 32768), ties up
  always_comb begin
    prod    = PROD_W'(raw) * PROD_W'($signed({1'b0, fs}));
    wide    = {{(WW-PROD_W){prod[PROD_W-1]}}, prod};
    wide    = (wide <<< OUT_FRAC_BITS) + HALF;
    shifted = wide >>> SHIFT;
    if (shifted > SAT_HI) begin
      value = SAT_HI[AXIS_W-1:0];
    end else if (shifted < SAT_LO) begin
      value = SAT_LO[AXIS_W-1:0];
    end else begin
      value = shifted[AXIS_W-1:0];
    end
  end

endmodule

@@ hdl/imu_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// imu_packet_decoder
// Decodes the serial byte stream of a nine-axis inertial sensor into
// scaled acceleration, angular rate and angle results.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per request, in_tuser[0] marks the first byte
//           of a new frame and realigns the 11-byte slot counter.
//   out_* : one result per valid slot, out_tuser is the kind, out_tdata the
//           three axes in signed fixed point with OUT_FRAC_BITS fraction bits.
//   cfg_* : writes the header byte expected at slot byte 0, always ready.
// Throughput is one byte per cycle while in_tready is high. A result is
// in the output register in the cycle after the slot's last byte is accepted;
// the scaling is one constant multiply and a rounding add per axis between
// the slot registers and the output register.
// Reset clears the slot counter, the header flag and the kind and sets the
// header byte to 0x55. While a result waits on out_tready, bytes keep being
// accepted; only the last byte of the next slot waits for the output
// register to drain.
// ----------------------------------------------------------------------------
module imu_packet_decoder #(
  parameter int OUT_FRAC_BITS = imu_pkt_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [imu_pkt_pkg::BYTE_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                     in_tuser,   // [0] first_of_frame
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [87:0]                    out_tdata,  // [27:0] x, [55:28] y, [83:56] z
  output logic [1:0]                     out_tuser   // [1:0] kind
);
  import imu_pkt_pkg::*;

  slot_evt_t                evt;
  logic                     at_last;
  logic                     in_fire;
  logic signed [AXIS_W-1:0] sx;
  logic signed [AXIS_W-1:0] sy;
  logic signed [AXIS_W-1:0] sz;

  logic                     out_valid_r;
  kind_t                    out_kind_r;
  logic signed [AXIS_W-1:0] out_x_r;
  logic signed [AXIS_W-1:0] out_y_r;
  logic signed [AXIS_W-1:0] out_z_r;

  assign cfg_ready = 1'b1;
  // only a slot's last byte can make a result, hold it while output is full
  assign in_tready = !out_valid_r || out_tready || !at_last;
  assign in_fire   = in_tvalid && in_tready;

  imu_pkt_slot u_slot (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_fire        (in_fire),
    .rx_byte        (in_tdata[7:0]),
    .first_of_frame (in_tuser[0]),
    .at_last        (at_last),
    .evt            (evt)
  );

  imu_pkt_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale_x (
    .raw   (evt.raw_x),
    .kind  (evt.kind),
    .value (sx)
  );

  imu_pkt_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale_y (
    .raw   (evt.raw_y),
    .kind  (evt.kind),
    .value (sy)
  );

  imu_pkt_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale_z (
    .raw   (evt.raw_z),
    .kind  (evt.kind),
    .value (sz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && evt.hit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && evt.hit) begin
      out_kind_r <= evt.kind;
      out_x_r    <= sx;
      out_y_r    <= sy;
      out_z_r    <= sz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0, out_z_r, out_y_r, out_x_r};

endmodule
